@@ rtl/actr_pkg.sv @@
`timescale 1ns / 1ps
package actr_pkg;
	localparam int QueueDepth = 2;
	localparam logic [2:0] REG_KEY_HIGH = 3'd0;
	localparam logic [2:0] REG_KEY_LOW = 3'd1;
	localparam logic [2:0] REG_NONCE_HIGH = 3'd2;
	localparam logic [2:0] REG_NONCE_LOW = 3'd3;
	localparam logic [2:0] REG_START_COUNTER = 3'd4;

	typedef struct packed {
		logic [127:0] text;
		logic [4:0]   count;
		logic         first;
		logic [31:0]  ctr;
	} job_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction
endpackage

@@ rtl/actr_front.sv @@
`timescale 1ns / 1ps
module actr_front import actr_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [127:0] in_text,
	input  logic [4:0]   in_count,
	input  logic         in_first,
	input  logic [31:0]  start_counter,
	output logic         job_valid,
	input  logic         job_take,
	output job_t         job
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	job_t          mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   fill_q;
	logic [31:0]   ctr_q;
	logic          push;
	logic [31:0]   ctr_use;

	assign in_stall  = (fill_q == (AW+1)'(Depth));
	assign push      = in_valid && !in_stall;
	assign job_valid = (fill_q != '0);
	assign job       = mem_q[rd_q];
	assign ctr_use   = in_first ? start_counter : ctr_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= '{text: in_text, count: in_count, first: in_first, ctr: ctr_use};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; fill_q <= '0; ctr_q <= '0;
		end else begin
			if (push) begin
				ctr_q <= ctr_use + 32'd1;
				wr_q  <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + AW'(1);
			end
			if (job_take) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + AW'(1);
			fill_q <= fill_q + (AW+1)'(push) - (AW+1)'(job_take);
		end
	end
endmodule

@@ rtl/actr_back.sv @@
`timescale 1ns / 1ps
module actr_back import actr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	output logic         job_take,
	output logic         key_start,
	input  job_t         job,
	input  logic [127:0] key,
	input  logic [95:0]  nonce,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [127:0] out_text,
	output logic [4:0]   out_count
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001, ST_KEY = 3'b010, ST_RUN = 3'b100
	} state_t;
	state_t         state_q;
	logic [127:0]   rk_q [11];
	logic [127:0]   kgen_q, st_q, text_q;
	logic [7:0]     rc_q;
	logic [3:0]     rnd_q;
	logic [4:0]     cnt_q;
	logic [127:0]   kn, rs, mixed;
	logic [7:0]     sb [16];
	logic [31:0]    kt;

	// next round key from the previous one
	always_comb begin
		kt = sub_word({kgen_q[23:0], kgen_q[31:24]}) ^ {rc_q, 24'd0};
		kn[127:96] = kgen_q[127:96] ^ kt;
		kn[95:64]  = kgen_q[95:64] ^ kn[127:96];
		kn[63:32]  = kgen_q[63:32] ^ kn[95:64];
		kn[31:0]   = kgen_q[31:0] ^ kn[63:32];
	end

	// one round: sub bytes, shift rows, mix columns (mix columns skipped in the last round)
	always_comb begin
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sb[r+4*c] = SBOX[st_q[127-8*(r+4*((c+r)%4)) -: 8]];
		for (int c = 0; c < 4; c++) begin
			a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			mixed[127-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
			mixed[119-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
			mixed[111-32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
			mixed[103-32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
		end
		for (int i = 0; i < 16; i++) rs[127-8*i -: 8] = sb[i];
		if (rnd_q != 4'd10) rs = mixed;
	end

	assign job_take  = (state_q == ST_IDLE) && job_valid && !job.first && !out_valid;
	assign key_start = (state_q == ST_IDLE) && job_valid && job.first && !out_valid;

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) rk_q[rnd_q] <= kgen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; out_valid <= 1'b0; rnd_q <= '0; rc_q <= 8'h01;
			kgen_q <= '0; st_q <= '0; text_q <= '0; cnt_q <= '0;
			out_text <= '0; out_count <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid && !out_valid) begin
						if (job.first) begin
							kgen_q <= key; rc_q <= 8'h01; rnd_q <= '0; state_q <= ST_KEY;
						end else begin
							st_q   <= {nonce, job.ctr} ^ rk_q[0];
							text_q <= job.text; cnt_q <= job.count;
							rnd_q  <= 4'd1; state_q <= ST_RUN;
						end
					end
				end
				ST_KEY: begin
					kgen_q <= kn; rc_q <= xtime(rc_q);
					if (rnd_q == 4'd10) begin
						// back to idle; actr_first_clr has already dropped the flag, so the word then runs as usual
						state_q <= ST_IDLE;
					end
					rnd_q <= rnd_q + 4'd1;
				end
				ST_RUN: begin
					st_q  <= rs ^ rk_q[rnd_q];
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd10) begin
						for (int i = 0; i < 16; i++)
							out_text[127-8*i -: 8] <= (5'(i) < cnt_q) ?
								(text_q[127-8*i -: 8] ^ rs[127-8*i -: 8] ^ rk_q[10][127-8*i -: 8])
								: 8'h00;
						out_count <= cnt_q; out_valid <= 1'b1; state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/actr_first_clr.sv @@
`timescale 1ns / 1ps
// clears the first flag of the head word once the back end starts expanding its keys
module actr_first_clr import actr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job_in,
	input  logic key_start,
	input  logic job_take,
	output job_t job_out
);
	logic done_q;
	// set only when the back end really starts expanding for this word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else if (job_take) done_q <= 1'b0;
		else if (key_start) done_q <= 1'b1;
	end
	always_comb begin
		job_out = job_in;
		if (done_q) job_out.first = 1'b0;
	end
endmodule

@@ rtl/aes128_ctr_cipher.sv @@
`timescale 1ns / 1ps
// Each word passes a hand-over with key XOR and ten rounds; a first block expands its keys first.
// The single shared round unit works on one word at a time and takes the next once the result is taken.
// A two-entry queue lets input words pile up while the round unit works.
// Reset: asynchronous, active low; counter and registers clear, round keys undefined until expanded.
module aes128_ctr_cipher import actr_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] text_high,
	input  logic [63:0] text_low,
	input  logic [4:0]  valid_bytes,
	input  logic        first_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	output logic [4:0]  result_bytes
);
	logic [63:0] key_high_q, key_low_q, nonce_high_q;
	logic [31:0] nonce_low_q, start_q;
	logic        job_valid, job_take, key_start;
	job_t        job_raw, job;
	logic [127:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0; key_low_q <= '0; nonce_high_q <= '0;
			nonce_low_q <= '0; start_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH:      key_high_q   <= cfg_data;
				REG_KEY_LOW:       key_low_q    <= cfg_data;
				REG_NONCE_HIGH:    nonce_high_q <= cfg_data;
				REG_NONCE_LOW:     nonce_low_q  <= cfg_data[31:0];
				REG_START_COUNTER: start_q      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	actr_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_text({text_high, text_low}), .in_count(valid_bytes), .in_first(first_block),
		.start_counter(start_q), .job_valid, .job_take, .job(job_raw)
	);

	actr_first_clr u_clr (
		.clk, .arst_n, .job_in(job_raw), .key_start, .job_take, .job_out(job)
	);

	actr_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .key_start, .job,
		.key({key_high_q, key_low_q}), .nonce({nonce_high_q, nonce_low_q}),
		.out_valid, .out_stall, .out_text(res), .out_count(result_bytes)
	);

	assign result_high = res[127:64];
	assign result_low  = res[63:0];
endmodule
